// ===== hw/rtl/rbcf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbcf_pkg
// Shared types and constants of the remote button command framer.
// ----------------------------------------------------------------------------
`default_nettype none

package rbcf_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ID_ONE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ID_TWO     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ID_THREE   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_EMERGENCY_REPEATS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_STOP_REPEATS      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_FINE_LIMIT   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_COARSE_LIMIT = 3'd6;

	localparam logic [7:0] RST_TARGET_ID_ONE     = 8'd117;
	localparam logic [7:0] RST_TARGET_ID_TWO     = 8'd45;
	localparam logic [7:0] RST_TARGET_ID_THREE   = 8'd46;
	localparam logic [4:0] RST_EMERGENCY_REPEATS = 5'd20;
	localparam logic [4:0] RST_STOP_REPEATS      = 5'd30;
	localparam logic [15:0] RST_IDLE_FINE_LIMIT  = 16'd2000;
	localparam logic [9:0] RST_IDLE_COARSE_LIMIT = 10'd480;

	localparam logic [7:0] PKT_HEADER    = 8'h55;
	localparam logic [7:0] PKT_OPCODE    = 8'h11;
	localparam logic [7:0] CMD_EMERGENCY = 8'd64;
	localparam logic [7:0] CMD_STOP      = 8'd255;

	localparam logic [4:0] BLINK_ON_BELOW   = 5'd10;
	localparam logic [4:0] BLINK_WRAP       = 5'd20;
	localparam logic [5:0] SLEEP_ON_BELOW   = 6'd3;
	localparam logic [5:0] SLEEP_BLINK_MAX  = 6'd50;
	localparam logic [9:0] COARSE_WRAP      = 10'd1000;

	localparam logic [2:0] BEAT_HEADER = 3'd0;
	localparam logic [2:0] BEAT_ID_ONE = 3'd1;
	localparam logic [2:0] BEAT_ID_TWO = 3'd2;
	localparam logic [2:0] BEAT_ID_THR = 3'd3;
	localparam logic [2:0] BEAT_OPCODE = 3'd4;
	localparam logic [2:0] BEAT_CMD0   = 3'd5;
	localparam logic [2:0] BEAT_CMD1   = 3'd6;

	typedef struct packed {
		logic [7:0]  target_id_one;
		logic [7:0]  target_id_two;
		logic [7:0]  target_id_three;
		logic [4:0]  emergency_repeats;
		logic [4:0]  stop_repeats;
		logic [15:0] idle_fine_limit;
		logic [9:0]  idle_coarse_limit;
	} cfg_t;

	typedef struct packed {
		logic       send;
		logic [7:0] cmd0;
		logic [7:0] cmd1;
		logic       radio_sleep;
		logic       led_power;
		logic       led_alarm;
	} job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rbcf_front.sv =====
// ----------------------------------------------------------------------------
// rbcf_front
// Classifies one button scan, updates counters, timers and LEDs, emits a job.
// ----------------------------------------------------------------------------
`default_nettype none

module rbcf_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rbcf_pkg::cfg_t cfg,
	input  wire logic          scan_valid,
	output logic               scan_ready,
	input  wire logic          emergency_pressed,
	input  wire logic [5:0]    buttons_first,
	input  wire logic [5:0]    buttons_second,
	output logic               job_push,
	output rbcf_pkg::job_t     job,
	input  wire logic          queue_full
);
	import rbcf_pkg::*;

	logic [4:0]  emergency_count_q, emergency_count_n;
	logic [4:0]  stop_count_q, stop_count_n;
	logic [4:0]  blink_count_q, blink_count_n;
	logic [7:0]  last_command_q, last_command_n;
	logic [15:0] idle_fine_q, idle_fine_n;
	logic [9:0]  idle_coarse_q, idle_coarse_n;
	logic [5:0]  sleep_blink_q, sleep_blink_n;
	logic        radio_asleep_q, radio_asleep_n;
	logic        power_led_q, power_led_n;
	logic        alarm_led_q, alarm_led_n;
	logic        send;
	logic [7:0]  cmd0, cmd1;
	logic        accept;

	assign scan_ready = !queue_full;
	assign accept     = scan_valid && scan_ready;
	assign job_push   = accept;

	always_comb begin
		logic [5:0]  any;
		logic        clash;
		logic [4:0]  blink_inc;
		logic [15:0] fine_inc;
		logic [9:0]  coarse_inc;
		logic [5:0]  sleep_inc;

		emergency_count_n = emergency_count_q;
		stop_count_n      = stop_count_q;
		blink_count_n     = blink_count_q;
		last_command_n    = last_command_q;
		idle_fine_n       = idle_fine_q;
		idle_coarse_n     = idle_coarse_q;
		sleep_blink_n     = sleep_blink_q;
		radio_asleep_n    = radio_asleep_q;
		power_led_n       = power_led_q;
		alarm_led_n       = alarm_led_q;
		send              = 1'b0;
		cmd0              = '0;
		cmd1              = '0;
		coarse_inc        = '0;
		sleep_inc         = '0;

		any       = buttons_first | buttons_second;
		clash     = (any[5:4] == 2'b11) || (any[3:2] == 2'b11) || (any[1:0] == 2'b11);
		blink_inc = blink_count_q + 5'd1;

		if (emergency_pressed) begin
			if (emergency_count_q < cfg.emergency_repeats) begin
				radio_asleep_n    = 1'b0;
				alarm_led_n       = 1'b1;
				power_led_n       = 1'b0;
				last_command_n    = CMD_EMERGENCY;
				cmd0              = CMD_EMERGENCY;
				send              = 1'b1;
				emergency_count_n = emergency_count_q + 5'd1;
			end
			if (emergency_count_n == cfg.emergency_repeats) begin
				idle_coarse_n  = '0;
				radio_asleep_n = 1'b1;
				alarm_led_n    = 1'b0;
				power_led_n    = 1'b0;
			end
		end else if (any != 6'd0) begin
			if (!clash) begin
				alarm_led_n       = 1'b0;
				emergency_count_n = '0;
				stop_count_n      = '0;
				radio_asleep_n    = 1'b0;
				idle_fine_n       = '0;
				idle_coarse_n     = '0;
				last_command_n    = {2'b00, buttons_first};
				cmd0              = {2'b00, buttons_first};
				cmd1              = {2'b00, buttons_second};
				send              = 1'b1;
				power_led_n       = (blink_inc < BLINK_ON_BELOW);
				blink_count_n     = (blink_inc == BLINK_WRAP) ? 5'd0 : blink_inc;
			end
		end else if (last_command_q != CMD_EMERGENCY) begin
			alarm_led_n = 1'b0;
			power_led_n = 1'b0;
			if (stop_count_q < cfg.stop_repeats) begin
				cmd0         = CMD_STOP;
				send         = 1'b1;
				stop_count_n = stop_count_q + 5'd1;
			end
		end

		// two-level idle timer
		fine_inc    = idle_fine_n + 16'd1;
		idle_fine_n = fine_inc;
		if (fine_inc > cfg.idle_fine_limit) begin
			idle_fine_n   = '0;
			coarse_inc    = idle_coarse_n + 10'd1;
			idle_coarse_n = coarse_inc;
			if (coarse_inc > cfg.idle_coarse_limit) begin
				radio_asleep_n = 1'b1;
				power_led_n    = 1'b0;
				sleep_inc      = sleep_blink_q + 6'd1;
				alarm_led_n    = (sleep_inc < SLEEP_ON_BELOW);
				sleep_blink_n  = (sleep_inc > SLEEP_BLINK_MAX) ? 6'd0 : sleep_inc;
				if (coarse_inc == COARSE_WRAP)
					idle_coarse_n = cfg.idle_coarse_limit + 10'd1;
			end
		end
	end

	assign job.send        = send;
	assign job.cmd0        = cmd0;
	assign job.cmd1        = cmd1;
	assign job.radio_sleep = radio_asleep_n;
	assign job.led_power   = power_led_n;
	assign job.led_alarm   = alarm_led_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emergency_count_q <= '0;
			stop_count_q      <= '0;
			blink_count_q     <= '0;
			last_command_q    <= '0;
			idle_fine_q       <= '0;
			idle_coarse_q     <= '0;
			sleep_blink_q     <= '0;
			radio_asleep_q    <= 1'b0;
			power_led_q       <= 1'b1;
			alarm_led_q       <= 1'b0;
		end else if (accept) begin
			emergency_count_q <= emergency_count_n;
			stop_count_q      <= stop_count_n;
			blink_count_q     <= blink_count_n;
			last_command_q    <= last_command_n;
			idle_fine_q       <= idle_fine_n;
			idle_coarse_q     <= idle_coarse_n;
			sleep_blink_q     <= sleep_blink_n;
			radio_asleep_q    <= radio_asleep_n;
			power_led_q       <= power_led_n;
			alarm_led_q       <= alarm_led_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rbcf_queue.sv =====
// ----------------------------------------------------------------------------
// rbcf_queue
// Small job queue between the scan front end and the packet serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module rbcf_queue #(
	parameter int unsigned DEPTH = rbcf_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire rbcf_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output rbcf_pkg::job_t      head_job
);
	import rbcf_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	job_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_job   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rbcf_back.sv =====
// ----------------------------------------------------------------------------
// rbcf_back
// Serializes each job into seven packet beats, or one empty status beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rbcf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rbcf_pkg::cfg_t cfg,
	input  wire logic           head_valid,
	input  wire rbcf_pkg::job_t head_job,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_byte,
	output logic                out_byte_valid,
	output logic                out_last,
	output logic [2:0]          out_status     // sleep, power led, alarm led
);
	import rbcf_pkg::*;

	logic [2:0] beat_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       byte_valid_q;
	logic       last_q;
	logic [2:0] status_q;
	logic       load;
	logic       last_beat;
	logic [7:0] beat_byte;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign last_beat = !head_job.send || (beat_q == BEAT_CMD1);
	assign pop       = load && last_beat;

	always_comb begin
		unique case (beat_q)
			BEAT_HEADER: beat_byte = PKT_HEADER;
			BEAT_ID_ONE: beat_byte = cfg.target_id_one;
			BEAT_ID_TWO: beat_byte = cfg.target_id_two;
			BEAT_ID_THR: beat_byte = cfg.target_id_three;
			BEAT_OPCODE: beat_byte = PKT_OPCODE;
			BEAT_CMD0:   beat_byte = head_job.cmd0;
			BEAT_CMD1:   beat_byte = head_job.cmd1;
			default:     beat_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= BEAT_HEADER;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				beat_q <= last_beat ? BEAT_HEADER : beat_q + 3'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q       <= head_job.send ? beat_byte : 8'd0;
			byte_valid_q <= head_job.send;
			last_q       <= last_beat;
			status_q     <= {head_job.led_alarm, head_job.led_power, head_job.radio_sleep};
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = byte_q;
	assign out_byte_valid = byte_valid_q;
	assign out_last       = last_q;
	assign out_status     = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/remote_button_command_framer.sv =====
// ----------------------------------------------------------------------------
// remote_button_command_framer
// Turns remote-control button scans into radio packets and LED/sleep status.
// ----------------------------------------------------------------------------
// An accepted scan's job is written into the job queue, then loaded beat by beat
//   into the single-byte output register: seven beats for a packet, one otherwise;
//   a stalled receiver holds the register, and scans are taken while the queue has room.
// Reset: asynchronous, active low; counters and timers clear, power LED lit,
//   configuration registers return to their defaults.
`default_nettype none

module remote_button_command_framer #(
	parameter int unsigned QUEUE_DEPTH = rbcf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [rbcf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [rbcf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// emergency_pressed[0], buttons_first[6:1], buttons_second[12:7], zero pad
	input  wire logic [15:0]                      s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// tx_byte[7:0], radio_sleep[8], led_power[9], led_alarm[10], zero pad
	output logic [15:0]                           m_axis_tdata,
	output logic                                  m_axis_tlast,
	// tx_valid[0]
	output logic [0:0]                            m_axis_tuser
);
	import rbcf_pkg::*;

	cfg_t       cfg_q;
	job_t       push_job, head_job;
	logic       job_push, queue_full, head_valid, pop;
	logic [7:0] out_byte;
	logic       out_byte_valid;
	logic [2:0] out_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_id_one     <= RST_TARGET_ID_ONE;
			cfg_q.target_id_two     <= RST_TARGET_ID_TWO;
			cfg_q.target_id_three   <= RST_TARGET_ID_THREE;
			cfg_q.emergency_repeats <= RST_EMERGENCY_REPEATS;
			cfg_q.stop_repeats      <= RST_STOP_REPEATS;
			cfg_q.idle_fine_limit   <= RST_IDLE_FINE_LIMIT;
			cfg_q.idle_coarse_limit <= RST_IDLE_COARSE_LIMIT;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_TARGET_ID_ONE:     cfg_q.target_id_one     <= cfg_data[7:0];
				CFG_TARGET_ID_TWO:     cfg_q.target_id_two     <= cfg_data[7:0];
				CFG_TARGET_ID_THREE:   cfg_q.target_id_three   <= cfg_data[7:0];
				CFG_EMERGENCY_REPEATS: cfg_q.emergency_repeats <= cfg_data[4:0];
				CFG_STOP_REPEATS:      cfg_q.stop_repeats      <= cfg_data[4:0];
				CFG_IDLE_FINE_LIMIT:   cfg_q.idle_fine_limit   <= cfg_data[15:0];
				CFG_IDLE_COARSE_LIMIT: cfg_q.idle_coarse_limit <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	rbcf_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.scan_valid        (s_axis_tvalid),
		.scan_ready        (s_axis_tready),
		.emergency_pressed (s_axis_tdata[0]),
		.buttons_first     (s_axis_tdata[6:1]),
		.buttons_second    (s_axis_tdata[12:7]),
		.job_push          (job_push),
		.job               (push_job),
		.queue_full        (queue_full)
	);

	rbcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	rbcf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head_valid     (head_valid),
		.head_job       (head_job),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_byte       (out_byte),
		.out_byte_valid (out_byte_valid),
		.out_last       (m_axis_tlast),
		.out_status     (out_status)
	);

	assign m_axis_tdata = {5'b00000, out_status, out_byte};
	assign m_axis_tuser = out_byte_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/rbcf_checker.sv =====
// ----------------------------------------------------------------------------
// rbcf_checker
// Port-level checks of the framer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rbcf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic [0:0]  m_axis_tuser
);

	// a scan without a packet is one beat with a zero byte
	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
		else $error("empty result beat not single or not zero");

	// status bits stay the same across the beats of one packet
	a_status_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> $stable(m_axis_tdata[10:8]))
		else $error("status changed inside a packet");

	// a packet continues with packet beats
	a_packet_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> $stable(m_axis_tuser))
		else $error("beat kind changed inside a packet");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result beat dropped or changed");

endmodule

bind remote_button_command_framer rbcf_checker u_rbcf_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for remote_button_command_framer. Button scans go in on
// the slave stream, packet bytes and status come out one beat at a time. A
// scoreboard predicts every output beat from its own model of the counters,
// idle timers and LEDs. Directed scans, idle runs and random scans run
// under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rbcf_pkg::*;

	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	class framer_scoreboard;
		typedef struct {
			logic [7:0] tx_byte;
			logic       tx_valid;
			logic       last;
			logic       sleep;
			logic       pwr;
			logic       alarm;
		} beat_t;

		beat_t       expected_beats[$];
		int          errors;
		cfg_t        regs;
		logic [4:0]  emer_cnt, stop_cnt, blink_cnt;
		logic [7:0]  last_cmd;
		logic [15:0] fine;
		logic [9:0]  coarse;
		logic [5:0]  sleep_blink;
		logic        asleep, pwr_led, alarm_led;

		function new();
			errors = 0;
			regs.target_id_one     = RST_TARGET_ID_ONE;
			regs.target_id_two     = RST_TARGET_ID_TWO;
			regs.target_id_three   = RST_TARGET_ID_THREE;
			regs.emergency_repeats = RST_EMERGENCY_REPEATS;
			regs.stop_repeats      = RST_STOP_REPEATS;
			regs.idle_fine_limit   = RST_IDLE_FINE_LIMIT;
			regs.idle_coarse_limit = RST_IDLE_COARSE_LIMIT;
			emer_cnt = '0; stop_cnt = '0; blink_cnt = '0; last_cmd = '0;
			fine = '0; coarse = '0; sleep_blink = '0;
			asleep = 1'b0; pwr_led = 1'b1; alarm_led = 1'b0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_TARGET_ID_ONE:     regs.target_id_one     = val[7:0];
				CFG_TARGET_ID_TWO:     regs.target_id_two     = val[7:0];
				CFG_TARGET_ID_THREE:   regs.target_id_three   = val[7:0];
				CFG_EMERGENCY_REPEATS: regs.emergency_repeats = val[4:0];
				CFG_STOP_REPEATS:      regs.stop_repeats      = val[4:0];
				CFG_IDLE_FINE_LIMIT:   regs.idle_fine_limit   = val[15:0];
				CFG_IDLE_COARSE_LIMIT: regs.idle_coarse_limit = val[9:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function void note_scan(logic emer, logic [5:0] b1, logic [5:0] b2);
			logic [7:0] pkt [7];
			logic       send;
			logic [7:0] c0, c1;
			logic [5:0] any;
			beat_t      b;
			int         n;
			send = 1'b0;
			c0 = '0;
			c1 = '0;
			any = b1 | b2;
			if (emer) begin
				if (emer_cnt < regs.emergency_repeats) begin
					asleep = 1'b0; alarm_led = 1'b1; pwr_led = 1'b0;
					last_cmd = CMD_EMERGENCY;
					c0 = CMD_EMERGENCY;
					send = 1'b1;
					emer_cnt = emer_cnt + 5'd1;
				end
				if (emer_cnt == regs.emergency_repeats) begin
					coarse = '0; asleep = 1'b1; alarm_led = 1'b0; pwr_led = 1'b0;
				end
			end else if (any != '0) begin
				if (!((any[5] && any[4]) || (any[3] && any[2]) || (any[1] && any[0]))) begin
					alarm_led = 1'b0; emer_cnt = '0; stop_cnt = '0;
					blink_cnt = blink_cnt + 5'd1;
					asleep = 1'b0; fine = '0; coarse = '0;
					last_cmd = {2'b00, b1};
					c0 = {2'b00, b1};
					c1 = {2'b00, b2};
					send = 1'b1;
					pwr_led = (blink_cnt < BLINK_ON_BELOW);
					if (blink_cnt == BLINK_WRAP)
						blink_cnt = '0;
				end
			end else if (last_cmd != CMD_EMERGENCY) begin
				alarm_led = 1'b0; pwr_led = 1'b0;
				if (stop_cnt < regs.stop_repeats) begin
					c0 = CMD_STOP;
					send = 1'b1;
					stop_cnt = stop_cnt + 5'd1;
				end
			end

			fine = fine + 16'd1;
			if (fine > regs.idle_fine_limit) begin
				fine = '0;
				coarse = coarse + 10'd1;
				if (coarse > regs.idle_coarse_limit) begin
					asleep = 1'b1; pwr_led = 1'b0;
					sleep_blink = sleep_blink + 6'd1;
					alarm_led = (sleep_blink < SLEEP_ON_BELOW);
					if (sleep_blink > SLEEP_BLINK_MAX)
						sleep_blink = '0;
					if (coarse == COARSE_WRAP)
						coarse = regs.idle_coarse_limit + 10'd1;
				end
			end

			pkt = '{PKT_HEADER, regs.target_id_one, regs.target_id_two,
				regs.target_id_three, PKT_OPCODE, c0, c1};
			n = send ? 7 : 1;
			for (int k = 0; k < n; k++) begin
				b.tx_byte  = send ? pkt[k] : 8'd0;
				b.tx_valid = send;
				b.last     = (k == n - 1);
				b.sleep    = asleep;
				b.pwr      = pwr_led;
				b.alarm    = alarm_led;
				expected_beats.push_back(b);
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_beat(logic [15:0] data, logic last, logic user);
			beat_t e;
			if (expected_beats.size() == 0) begin
				$error("output beat with nothing expected: tdata %h", data);
				errors++;
				return;
			end
			e = expected_beats.pop_front();
			compare_field("tx_byte", e.tx_byte, data[7:0]);
			compare_field("tx_valid", 8'(e.tx_valid), 8'(user));
			compare_field("last_of_step", 8'(e.last), 8'(last));
			compare_field("radio_sleep", 8'(e.sleep), 8'(data[8]));
			compare_field("led_power", 8'(e.pwr), 8'(data[9]));
			compare_field("led_alarm", 8'(e.alarm), 8'(data[10]));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wen = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic [15:0]            s_axis_tdata = '0;
	logic                   m_axis_tready = 1'b0;
	logic                   s_axis_tready;
	logic                   m_axis_tvalid;
	logic [15:0]            m_axis_tdata;
	logic                   m_axis_tlast;
	logic [0:0]             m_axis_tuser;

	framer_scoreboard sb = new();
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;

	remote_button_command_framer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// receiver back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 10);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// older beats are checked before a scan accepted on the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_scan(s_axis_tdata[0], s_axis_tdata[6:1], s_axis_tdata[12:7]);
			if (cfg_wen)
				sb.set_reg(cfg_index, cfg_data);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || cfg_wen)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_scan(logic emer, logic [5:0] b1, logic [5:0] b2);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, b2, b1, emer};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic idle_scans(int n);
		repeat (n) send_scan(1'b0, 6'd0, 6'd0);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(logic [7:0] id1, logic [7:0] id2, logic [7:0] id3,
			logic [4:0] er, logic [4:0] sr, logic [15:0] fl, logic [9:0] cl);
		drain();
		write_reg(CFG_TARGET_ID_ONE, CFG_DATA_W'(id1));
		write_reg(CFG_TARGET_ID_TWO, CFG_DATA_W'(id2));
		write_reg(CFG_TARGET_ID_THREE, CFG_DATA_W'(id3));
		write_reg(CFG_EMERGENCY_REPEATS, CFG_DATA_W'(er));
		write_reg(CFG_STOP_REPEATS, CFG_DATA_W'(sr));
		write_reg(CFG_IDLE_FINE_LIMIT, fl);
		write_reg(CFG_IDLE_COARSE_LIMIT, CFG_DATA_W'(cl));
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// direction press with no opposing pair, bits spread over both sets
	task automatic clean_direction();
		logic [5:0] b1, b2;
		int sel, where;
		b1 = '0;
		b2 = '0;
		for (int p = 0; p < 3; p++) begin
			sel = $urandom_range(0, 2);
			where = $urandom_range(0, 2);
			if (sel != 0) begin
				if (where != 1) b1[2*p + sel - 1] = 1'b1;
				if (where != 0) b2[2*p + sel - 1] = 1'b1;
			end
		end
		if ((b1 | b2) == '0)
			b1[$urandom_range(0, 5)] = 1'b1;
		send_scan(1'b0, b1, b2);
	endtask

	task automatic random_scan();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			send_scan(1'b1, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
		else if (pick < 65)
			clean_direction();
		else if (pick < 80)
			send_scan(1'b0, 6'($urandom_range(1, 63)), 6'($urandom_range(0, 63)));
		else
			send_scan(1'b0, 6'd0, 6'd0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every command kind and the opposing pairs
		send_scan(1'b1, 6'd0, 6'd0);
		send_scan(1'b0, 6'b100000, 6'd0);
		send_scan(1'b0, 6'b010000, 6'd0);
		send_scan(1'b0, 6'd0, 6'b101010);
		send_scan(1'b0, 6'b010101, 6'd0);
		send_scan(1'b0, 6'b110000, 6'd0);
		send_scan(1'b0, 6'b001000, 6'b000100);
		send_scan(1'b0, 6'b000011, 6'd0);
		send_scan(1'b0, 6'd63, 6'd63);
		idle_scans(2);
		send_scan(1'b1, 6'd63, 6'd63);
		idle_scans(1);

		// emergency limit reached, then lowered below the count
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		configure(8'h00, 8'hFF, 8'hA5, 5'd2, 5'd1, 16'd65534, 10'd998);
		repeat (3) send_scan(1'b1, 6'd0, 6'd0);
		idle_scans(1);
		send_scan(1'b0, 6'b000001, 6'b000010);
		idle_scans(2);
		repeat (3) send_scan(1'b1, 6'd0, 6'd0);
		configure(8'h00, 8'hFF, 8'hA5, 5'd1, 5'd1, 16'd65534, 10'd998);
		repeat (2) send_scan(1'b1, 6'd0, 6'd0);
		send_scan(1'b0, 6'd0, 6'b100000);

		// zero repeat limits, limits at field maximum
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		configure(8'hFF, 8'h00, 8'h5A, 5'd0, 5'd0, 16'hFFFF, 10'h3FF);
		send_scan(1'b1, 6'd0, 6'd0);
		send_scan(1'b0, 6'b000100, 6'd0);
		idle_scans(1);

		// idle timer: sleep blinking
		configure(8'd117, 8'd45, 8'd46, 5'd31, 5'd3, 16'd1, 10'd1);
		send_scan(1'b0, 6'b001000, 6'd0);
		idle_scans(24);

		for (int ph = 0; ph < 4; ph++) begin
			gaps_on = (ph < 3);
			stalls_on = (ph < 3);
			case (ph)
				2: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 5'd31, 5'd31,
					16'($urandom_range(1, 8)), 10'($urandom_range(1, 6)));
				3: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 5'd1, 5'd1, 16'd1, 10'd1);
				default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 5'($urandom_range(1, 4)),
					5'($urandom_range(1, 5)), 16'($urandom_range(1, 8)),
					10'($urandom_range(1, 6)));
			endcase
			repeat (12) random_scan();
		end

		drain();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/rbcf_pkg.sv
hw/rtl/rbcf_front.sv
hw/rtl/rbcf_queue.sv
hw/rtl/rbcf_back.sv
hw/rtl/remote_button_command_framer.sv
hw/rtl/rbcf_checker.sv
sim/testbench.sv
